>>> rtl/buddy_page_allocator_defines.svh
// Assertion helpers for the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bpa_pkg.sv
package bpa_pkg;

	localparam int DEF_ORDERS         = 15;
	localparam int DEF_REGIONS        = 3;
	localparam int DEF_MAX_PAGE_COUNT = 16384;

	localparam int FRAME_W  = 16;
	localparam int COUNT_W  = 14;
	localparam int STATUS_W = 2;
	localparam int LOG_W    = 5;

	localparam int REGION_FRAMES = 'h4000;
	localparam int LINK_BASE     = 'h4000;
	localparam int LINK_DEPTH    = 49152;
	localparam int LINK_AW       = $clog2(LINK_DEPTH);
	localparam int STEP_W        = $clog2(LINK_DEPTH + 1);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OOM       = 2'd1,
		ST_BAD_COUNT = 2'd2,
		ST_BAD_FRAME = 2'd3
	} status_t;

	// Ceiling of log2 for a page count of at least one.
	function automatic logic [LOG_W-1:0] ceil_log2(input logic [COUNT_W-1:0] count);
		logic [COUNT_W-1:0] v;
		logic [LOG_W-1:0]   p;
		v = count - COUNT_W'(1);
		p = '0;
		for (int i = 0; i < COUNT_W; i++) begin
			if (v[i]) p = LOG_W'(i + 1);
		end
		return p;
	endfunction

endpackage

>>> rtl/bpa_if.sv
interface bpa_req_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [bpa_pkg::COUNT_W-1:0]  page_count;
	logic [bpa_pkg::FRAME_W-1:0]  frame_number;

	modport source (output valid, opcode, page_count, frame_number, input ready);
	modport sink   (input valid, opcode, page_count, frame_number, output ready);
endinterface

interface bpa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bpa_pkg::STATUS_W-1:0] status;
	logic [bpa_pkg::FRAME_W-1:0]  result_frame;

	modport source (output valid, status, result_frame, input ready);
	modport sink   (input valid, status, result_frame, output ready);
endinterface

>>> rtl/bpa_ram.sv
module bpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

>>> rtl/buddy_page_allocator.sv
// Channel | Dir | Payload                               | Transaction
// req     | in  | opcode, page_count, frame_number       | valid && ready
// rsp     | out | status, result_frame                   | valid && ready
//
// Steps: a rejected request is accepted, then finished. An allocate scans the orders upward,
// splits through ASPLIT, ASPLIT2 and ASPLIT3 for each order, then takes the head (ATAKE, ATAKE2).
// A free visits each order, walks its list entry by entry (buddy included), then pushes.
// The link memory has one write port and one read port; its read is registered.
// Reset clears the order heads and the region count at once; links need no clearing pass.
// A result waits in the rsp register, finish holds while it is full; intake waits for finish.
module buddy_page_allocator #(
	parameter int ORDERS         = bpa_pkg::DEF_ORDERS,
	parameter int REGIONS        = bpa_pkg::DEF_REGIONS,
	parameter int MAX_PAGE_COUNT = bpa_pkg::DEF_MAX_PAGE_COUNT
) (
	input  logic       clk,
	input  logic       arst_n,
	bpa_req_if.sink    req,
	bpa_rsp_if.source  rsp
);

`include "buddy_page_allocator_defines.svh"

	localparam int FW        = bpa_pkg::FRAME_W;
	localparam int OW        = $clog2(ORDERS);
	localparam int AW        = bpa_pkg::LINK_AW;
	localparam int SW        = bpa_pkg::STEP_W;
	localparam int FRAME_END = bpa_pkg::LINK_BASE + REGIONS * bpa_pkg::REGION_FRAMES;
	localparam logic [OW-1:0] TOP = OW'(ORDERS - 1);

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_ASCAN   = 13'b0000000000010,
		S_ASPLIT  = 13'b0000000000100,
		S_ASPLIT2 = 13'b0000000001000,
		S_ASPLIT3 = 13'b0000000010000,
		S_ATAKE   = 13'b0000000100000,
		S_ATAKE2  = 13'b0000001000000,
		S_FLOOP   = 13'b0000010000000,
		S_FWALK   = 13'b0000100000000,
		S_FNEXT   = 13'b0001000000000,
		S_FUNLINK = 13'b0010000000000,
		S_FPUSH   = 13'b0100000000000,
		S_FINISH  = 13'b1000000000000
	} state_t;

	state_t                   state_q;
	logic [OW-1:0]            ord_q, req_ord_q;
	logic [1:0]               ru_q;
	logic [FW-1:0]            cur_q, buddy_q, walk_q, prev_q, blk_q;
	logic [SW-1:0]            steps_q;
	logic [FW-1:0]            heads_q [ORDERS];
	bpa_pkg::status_t         res_status_q;
	logic [FW-1:0]            res_frame_q;
	logic                     out_valid_q;
	logic [bpa_pkg::STATUS_W-1:0] out_status_q;
	logic [FW-1:0]            out_frame_q;
	logic                     rd_zero_s1;

	// link memory port
	logic                     link_we, link_re;
	logic [FW-1:0]            link_wframe, link_wdata, link_rframe;
	logic [FW-1:0]            link_rdata_raw, link_rdata;

	// request decode
	logic [bpa_pkg::LOG_W-1:0] req_log;
	logic                      bad_count, bad_frame;
	logic [FW-1:0]             head_cur, refill_base;

	assign req_log   = bpa_pkg::ceil_log2(req.page_count);
	assign bad_count = (req.page_count == '0)
		|| (32'(req.page_count) > 32'(MAX_PAGE_COUNT))
		|| (32'(req_log) > 32'(ORDERS - 1));
	assign bad_frame = (32'(req.frame_number) < 32'(bpa_pkg::LINK_BASE))
		|| (32'(req.frame_number) >= 32'(FRAME_END));

	assign head_cur    = heads_q[ord_q];
	assign refill_base = FW'({ru_q + 2'd1, 14'b0});
	assign link_rdata  = rd_zero_s1 ? '0 : link_rdata_raw;

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.result_frame = out_frame_q;

	// Link memory access per state; frames below the store read as zero and drop writes.
	always_comb begin
		link_we     = 1'b0;
		link_wframe = '0;
		link_wdata  = '0;
		link_re     = 1'b0;
		link_rframe = '0;
		unique case (state_q)
			S_ASCAN: begin
				if (head_cur == '0 && ord_q == TOP && 32'(ru_q) < 32'(REGIONS)) begin
					link_we     = 1'b1;
					link_wframe = refill_base;
				end
			end
			S_ASPLIT, S_ATAKE: begin
				link_re     = 1'b1;
				link_rframe = head_cur;
			end
			S_ASPLIT2: begin
				link_we     = 1'b1;
				link_wframe = blk_q;
				link_wdata  = blk_q ^ (FW'(1) << (ord_q - OW'(1)));
			end
			S_ASPLIT3: begin
				link_we     = 1'b1;
				link_wframe = buddy_q;
			end
			S_FWALK: begin
				link_re     = 1'b1;
				link_rframe = walk_q;
			end
			S_FUNLINK: begin
				if (prev_q != '0) begin
					link_we     = 1'b1;
					link_wframe = prev_q;
					link_wdata  = link_rdata;
				end
			end
			S_FPUSH: begin
				link_we     = 1'b1;
				link_wframe = cur_q;
				link_wdata  = head_cur;
			end
			default: ;
		endcase
	end

	logic w_in, r_in;
	assign w_in = (32'(link_wframe) >= 32'(bpa_pkg::LINK_BASE));
	assign r_in = (32'(link_rframe) >= 32'(bpa_pkg::LINK_BASE));

	bpa_ram #(
		.WIDTH(FW),
		.DEPTH(bpa_pkg::LINK_DEPTH)
	) u_links (
		.clk  (clk),
		.we   (link_we && w_in),
		.waddr(AW'(link_wframe - FW'(bpa_pkg::LINK_BASE))),
		.wdata(link_wdata),
		.re   (link_re),
		.raddr(AW'(link_rframe - FW'(bpa_pkg::LINK_BASE))),
		.rdata(link_rdata_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ru_q        <= '0;
			out_valid_q <= 1'b0;
			rd_zero_s1  <= 1'b0;
			for (int i = 0; i < ORDERS; i++) heads_q[i] <= '0;
		end else begin
			if (link_re) rd_zero_s1 <= !r_in;
			// load the result register when it is free, drop it once taken
			if (state_q == S_FINISH && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						ord_q     <= OW'(req_log);
						req_ord_q <= OW'(req_log);
						cur_q     <= req.frame_number;
						res_frame_q <= '0;
						if (bad_count) begin
							res_status_q <= bpa_pkg::ST_BAD_COUNT;
							state_q      <= S_FINISH;
						end else if (!req.opcode) begin
							res_status_q <= bpa_pkg::ST_OK;
							state_q      <= S_ASCAN;
						end else if (bad_frame) begin
							res_status_q <= bpa_pkg::ST_BAD_FRAME;
							state_q      <= S_FINISH;
						end else begin
							res_status_q <= bpa_pkg::ST_OK;
							state_q      <= S_FLOOP;
						end
					end
				end
				S_ASCAN: begin
					if (head_cur != '0) begin
						state_q <= (ord_q == req_ord_q) ? S_ATAKE : S_ASPLIT;
					end else if (ord_q != TOP) begin
						ord_q <= ord_q + OW'(1);
					end else if (32'(ru_q) >= 32'(REGIONS)) begin
						res_status_q <= bpa_pkg::ST_OOM;
						state_q      <= S_FINISH;
					end else begin
						// bring the next region into the top list
						heads_q[TOP] <= refill_base;
						ru_q         <= ru_q + 2'd1;
						state_q <= (ord_q == req_ord_q) ? S_ATAKE : S_ASPLIT;
					end
				end
				S_ASPLIT: begin
					blk_q   <= head_cur;
					state_q <= S_ASPLIT2;
				end
				S_ASPLIT2: begin
					heads_q[ord_q]          <= link_rdata;
					heads_q[ord_q - OW'(1)] <= blk_q;
					buddy_q <= blk_q ^ (FW'(1) << (ord_q - OW'(1)));
					ord_q   <= ord_q - OW'(1);
					state_q <= S_ASPLIT3;
				end
				S_ASPLIT3: begin
					state_q <= (ord_q > req_ord_q) ? S_ASPLIT : S_ATAKE;
				end
				S_ATAKE: begin
					blk_q   <= head_cur;
					state_q <= S_ATAKE2;
				end
				S_ATAKE2: begin
					heads_q[ord_q] <= link_rdata;
					res_frame_q    <= blk_q;
					state_q        <= S_FINISH;
				end
				S_FLOOP: begin
					if (ord_q < TOP) begin
						buddy_q <= cur_q ^ (FW'(1) << ord_q);
						walk_q  <= head_cur;
						prev_q  <= '0;
						steps_q <= '0;
						state_q <= S_FWALK;
					end else begin
						state_q <= S_FPUSH;
					end
				end
				S_FWALK: begin
					if (walk_q == '0 || 32'(steps_q) == 32'(bpa_pkg::LINK_DEPTH)) begin
						state_q <= S_FPUSH;
					end else if (walk_q == buddy_q) begin
						state_q <= S_FUNLINK;
					end else begin
						prev_q  <= walk_q;
						state_q <= S_FNEXT;
					end
				end
				S_FNEXT: begin
					walk_q  <= link_rdata;
					steps_q <= steps_q + SW'(1);
					state_q <= S_FWALK;
				end
				S_FUNLINK: begin
					if (prev_q == '0) heads_q[ord_q] <= link_rdata;
					if (buddy_q < cur_q) cur_q <= buddy_q;
					ord_q   <= ord_q + OW'(1);
					state_q <= S_FLOOP;
				end
				S_FPUSH: begin
					heads_q[ord_q] <= cur_q;
					state_q        <= S_FINISH;
				end
				S_FINISH: begin
					// hold until the result register is free
					if (!out_valid_q || rsp.ready) begin
						out_status_q <= res_status_q;
						out_frame_q  <= res_frame_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BPA_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, req.valid && req.ready, state_q != S_IDLE, "accepted request did not start")
	`BPA_ASSERT_IMPLY(a_regions_bound, clk, arst_n, 1'b1, 32'(ru_q) <= 32'(REGIONS), "region count above limit")
	`BPA_ASSERT_IMPLY(a_oom_only_full, clk, arst_n, rsp.valid && rsp.status == bpa_pkg::ST_OOM, 32'(ru_q) == 32'(REGIONS), "out of memory with regions left")
	`BPA_ASSERT_IMPLY(a_error_zero_frame, clk, arst_n, rsp.valid && rsp.status != bpa_pkg::ST_OK, rsp.result_frame == '0, "error result carries a frame")

endmodule
